### rtl/table_linear_interpolator_macros.svh
// Assertion macros for the table linear interpolator checker.
// Included by the checker file; no other dependencies.
`ifndef TABLE_LINEAR_INTERPOLATOR_MACROS_SVH
`define TABLE_LINEAR_INTERPOLATOR_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define TLI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TLI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tli_pkg.sv
// Shared types and constants for the table linear interpolator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tli_pkg;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic ERR_OK      = 1'b0;
    localparam logic ERR_EQUAL_X = 1'b1;

    localparam int MAG_W     = 33;   // magnitude of a Q16.16 difference
    localparam int PROD_W    = 65;   // product of two magnitudes
    localparam int QUOT_W    = 34;
    localparam int DIV_STEPS = 34;
    localparam int DCNT_W    = 6;

    localparam logic [QUOT_W-1:0] QUOT_CLAMP = 34'h2_0000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FETCH_A,
        ST_FETCH_B,
        ST_FETCH_C,
        ST_MAG,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DIV,
        ST_DIV_WAIT,
        ST_FINAL,
        ST_OUT
    } tli_state_t;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [MAG_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_rsp_t;

endpackage

`default_nettype wire

### rtl/tli_div.sv
// Restoring divider, one quotient bit per cycle, quotient clamped to 2^33.
// Depends on tli_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tli_div
    import tli_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [QUOT_W-1:0] rem_reg;
    logic [QUOT_W-1:0] dvd_reg;
    logic [QUOT_W-1:0] quo_reg;
    logic [MAG_W-1:0]  dvs_reg;
    logic              ovf_reg;

    logic [QUOT_W-1:0] rem_sh;
    logic              q_bit;

    assign rem_sh = {rem_reg[QUOT_W-2:0], dvd_reg[QUOT_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            // high part at or above divisor means quotient >= 2^34
            ovf_reg <= ({2'b00, req.dividend[PROD_W-1:QUOT_W]} >= req.divisor);
            rem_reg <= {3'b000, req.dividend[PROD_W-1:QUOT_W]};
            dvd_reg <= req.dividend[QUOT_W-1:0];
            dvs_reg <= req.divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= q_bit ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
            dvd_reg <= {dvd_reg[QUOT_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUOT_W-2:0], q_bit};
        end
    end

    always_comb
    begin
        rsp.done = done_reg;
        rsp.quot = (ovf_reg || (quo_reg > QUOT_CLAMP)) ? QUOT_CLAMP : quo_reg;
    end

endmodule

`default_nettype wire

### rtl/table_linear_interpolator.sv
// Piecewise linear interpolation over a table of up to MAX_POINTS signed Q16.16
// (x, y) points. A write request (command 0) stores one point and produces no
// result; slots at or above MAX_POINTS are dropped. A query request (command 1)
// scans the first points_in_use entries (clamped to 2..MAX_POINTS) for the x
// nearest query_x (ties keep the lower slot; the last slot steps back one), then
// evaluates the line through that point and the next at query_x, saturated to
// Q16.16. Equal segment x values give zero with error_code 1. A query makes one
// table read per scanned point, then runs a 34-step bit-serial divider. Table
// contents are undefined until written; there is no clearing pass. The result
// register lets the next request in while a result waits on out_ready.
`timescale 1ns / 1ps
`default_nettype none

module table_linear_interpolator
    import tli_pkg::*;
#(
    parameter int MAX_POINTS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [4:0]  cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        command,
    input  wire logic [3:0]  entry_index,
    input  wire logic signed [31:0] point_x,
    input  wire logic signed [31:0] point_y,
    input  wire logic signed [31:0] query_x,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic signed [31:0] result_y,
    output logic             error_code
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    tli_state_t state_reg, state_next;

    logic [4:0]       points_in_use_reg;

    logic [31:0]      mem_x [MAX_POINTS];
    logic [31:0]      mem_y [MAX_POINTS];
    logic [31:0]      rd_x_reg;
    logic [31:0]      rd_y_reg;
    logic [IDX_W-1:0] raddr;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W+3:0] waddr_ext;
    logic             mem_we;
    logic             in_acc;
    logic             idx_ok;

    logic [31:0]      q_reg;
    logic [IDX_W-1:0] last_reg;
    logic [IDX_W-1:0] last_calc;
    int               last_i;

    logic [IDX_W-1:0] scan_idx_reg;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             dist_vld_reg;
    logic [IDX_W-1:0] dist_idx_reg;
    logic [MAG_W-1:0] dist_reg;
    logic [MAG_W-1:0] best_dist_reg;
    logic [IDX_W-1:0] best_reg;
    logic signed [MAG_W-1:0] diff_q;

    logic [IDX_W-1:0] seg_idx;
    logic [IDX_W-1:0] seg_idx_reg;
    logic [31:0]      x1_reg;
    logic [31:0]      y1_reg;
    logic signed [MAG_W-1:0] dx_reg, dy_reg, dq_reg;
    logic [MAG_W-1:0] mag_dx_reg, mag_dy_reg, mag_dq_reg;
    logic             neg_reg;

    logic [16:0]      mul_b;
    logic [49:0]      mul_out;
    logic [PROD_W-1:0] prod_reg;

    div_req_t         div_req;
    div_rsp_t         div_rsp;
    logic [QUOT_W-1:0] quot_reg;

    logic signed [34:0] y_sum;
    logic [31:0]      y_sat;

    logic [31:0]      res_y_reg;
    logic             res_err_reg;
    logic             out_valid_reg;
    logic [31:0]      result_y_reg;
    logic             error_code_reg;
    logic             out_load;

    // ------------------------------------------------------------------
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign waddr_ext = {{IDX_W{1'b0}}, entry_index};
    assign waddr     = waddr_ext[IDX_W-1:0];
    assign idx_ok    = (int'(entry_index) < MAX_POINTS);
    assign mem_we    = in_acc && (command == CMD_WRITE) && idx_ok;

    // clamp the point count to [2, MAX_POINTS]; keep the last index
    always_comb
    begin
        last_i = int'(points_in_use_reg) - 1;
        if (points_in_use_reg < 5'd2)
        begin
            last_i = 1;
        end
        if (int'(points_in_use_reg) > MAX_POINTS)
        begin
            last_i = MAX_POINTS - 1;
        end
        last_calc = last_i[IDX_W-1:0];
    end

    // last slot steps back one
    assign seg_idx = (best_reg == last_reg) ? (best_reg - 1'b1) : best_reg;

    // ------------------------------------------------------------------
    // table memories
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_x[waddr] <= point_x;
            mem_y[waddr] <= point_y;
        end
        rd_x_reg <= mem_x[raddr];
        rd_y_reg <= mem_y[raddr];
    end

    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (command == CMD_QUERY))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == last_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (dist_vld_reg && (dist_idx_reg == last_reg))
                begin
                    state_next = ST_FETCH_A;
                end
            end
            ST_FETCH_A:  state_next = ST_FETCH_B;
            ST_FETCH_B:  state_next = ST_FETCH_C;
            ST_FETCH_C:  state_next = ST_MAG;
            ST_MAG:      state_next = (dx_reg == '0) ? ST_OUT : ST_MUL_LO;
            ST_MUL_LO:   state_next = ST_MUL_HI;
            ST_MUL_HI:   state_next = ST_DIV;
            ST_DIV:      state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:    state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        raddr    = '0;
        out_load = 1'b0;
        mul_b    = {1'b0, mag_dq_reg[15:0]};
        case (state_reg)
            ST_SCAN:    raddr = scan_idx_reg;
            ST_FETCH_A: raddr = seg_idx;
            ST_FETCH_B: raddr = seg_idx_reg + 1'b1;
            ST_MUL_HI:  mul_b = mag_dq_reg[32:16];
            ST_OUT:     out_load = !out_valid_reg || out_ready;
            default:    raddr = '0;
        endcase
    end

    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            points_in_use_reg <= 5'd2;
            rd_vld_reg        <= 1'b0;
            dist_vld_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_vld_reg   <= (state_reg == ST_SCAN);
            dist_vld_reg <= rd_vld_reg;
            if (cfg_wr_en)
            begin
                points_in_use_reg <= cfg_wr_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath
    assign diff_q  = $signed({q_reg[31], q_reg}) - $signed({rd_x_reg[31], rd_x_reg});
    assign mul_out = mag_dy_reg * mul_b;

    assign div_req.start    = (state_reg == ST_DIV);
    assign div_req.dividend = prod_reg;
    assign div_req.divisor  = mag_dx_reg;

    always_comb
    begin
        if (neg_reg)
        begin
            y_sum = $signed({{3{y1_reg[31]}}, y1_reg}) - $signed({1'b0, quot_reg});
        end
        else
        begin
            y_sum = $signed({{3{y1_reg[31]}}, y1_reg}) + $signed({1'b0, quot_reg});
        end
        if ((y_sum[34:31] == 4'b0000) || (y_sum[34:31] == 4'b1111))
        begin
            y_sat = y_sum[31:0];
        end
        else
        begin
            y_sat = y_sum[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && (command == CMD_QUERY))
        begin
            q_reg        <= query_x;
            last_reg     <= last_calc;
            scan_idx_reg <= '0;
        end
        else if (state_reg == ST_SCAN)
        begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end

        rd_idx_reg   <= scan_idx_reg;
        dist_idx_reg <= rd_idx_reg;
        dist_reg     <= diff_q[MAG_W-1] ? MAG_W'(-diff_q) : MAG_W'(diff_q);

        // strict compare keeps the earliest on a tie
        if (dist_vld_reg && ((dist_idx_reg == '0) || (dist_reg < best_dist_reg)))
        begin
            best_dist_reg <= dist_reg;
            best_reg      <= dist_idx_reg;
        end

        if (state_reg == ST_FETCH_A)
        begin
            seg_idx_reg <= seg_idx;
        end
        if (state_reg == ST_FETCH_B)
        begin
            x1_reg <= rd_x_reg;
            y1_reg <= rd_y_reg;
        end
        if (state_reg == ST_FETCH_C)
        begin
            dx_reg <= $signed({rd_x_reg[31], rd_x_reg}) - $signed({x1_reg[31], x1_reg});
            dy_reg <= $signed({rd_y_reg[31], rd_y_reg}) - $signed({y1_reg[31], y1_reg});
            dq_reg <= $signed({q_reg[31], q_reg}) - $signed({x1_reg[31], x1_reg});
        end
        if (state_reg == ST_MAG)
        begin
            mag_dx_reg <= dx_reg[MAG_W-1] ? MAG_W'(-dx_reg) : MAG_W'(dx_reg);
            mag_dy_reg <= dy_reg[MAG_W-1] ? MAG_W'(-dy_reg) : MAG_W'(dy_reg);
            mag_dq_reg <= dq_reg[MAG_W-1] ? MAG_W'(-dq_reg) : MAG_W'(dq_reg);
            neg_reg    <= dy_reg[MAG_W-1] ^ dq_reg[MAG_W-1] ^ dx_reg[MAG_W-1];
            res_y_reg  <= '0;
            res_err_reg <= ERR_EQUAL_X;
        end
        if (state_reg == ST_MUL_LO)
        begin
            prod_reg <= PROD_W'(mul_out);
        end
        if (state_reg == ST_MUL_HI)
        begin
            prod_reg <= prod_reg + PROD_W'({mul_out, 16'h0000});
        end
        if (div_rsp.done)
        begin
            quot_reg <= div_rsp.quot;
        end
        if (state_reg == ST_FINAL)
        begin
            res_y_reg   <= y_sat;
            res_err_reg <= ERR_OK;
        end
        if (out_load)
        begin
            result_y_reg   <= res_y_reg;
            error_code_reg <= res_err_reg;
        end
    end

    tli_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_valid  = out_valid_reg;
    assign result_y   = result_y_reg;
    assign error_code = error_code_reg;

endmodule

`default_nettype wire

### rtl/tli_checker.sv
// Port-level checks for the table linear interpolator, bound to the top level.
// Depends on tli_pkg and table_linear_interpolator_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "table_linear_interpolator_macros.svh"

module tli_checker
    import tli_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        command,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] result_y,
    input wire logic        error_code
)
;

    `TLI_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(result_y) && $stable(error_code), "stalled result changed")

    `TLI_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && (error_code == ERR_EQUAL_X), result_y == 32'h0000_0000, "error result not zero")

    `TLI_ASSERT_NXT(a_query_busy, clk, rst_n, in_valid && in_ready && (command == CMD_QUERY), !in_ready, "query request did not occupy the block")

    `TLI_ASSERT_NXT(a_write_fast, clk, rst_n, in_valid && in_ready && (command == CMD_WRITE), in_ready, "write request stalled the input")

endmodule

bind table_linear_interpolator tli_checker u_tli_checker (.*);

`default_nettype wire

### tb/sv/tb_table_linear_interpolator.sv
`timescale 1ns / 1ps
// Testbench for table_linear_interpolator: directed and random write/query requests,
// with each result checked against an in-bench model of the nearest-point search.
// Depends on tli_pkg and the table_linear_interpolator RTL.
module tb_table_linear_interpolator;
    import tli_pkg::*;

    localparam int TABLE_DEPTH     = 16;
    localparam int SETTLE_CYCLES   = 80;    // outlasts a 16-point query
    localparam int STALL_LIMIT     = 5000;
    localparam int HOLD_CYCLES     = 300;
    localparam int ITEMS_PER_PHASE = 131;
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic               command;
        logic [3:0]         entry_index;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] query_x;
    } interp_req_t;

    typedef struct packed {
        logic signed [31:0] result_y;
        logic               error_code;
    } interp_res_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [4:0]         cfg_wr_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    interp_req_t        offer = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] result_y;
    logic               error_code;

    interp_req_t        pending_reqs[$];
    interp_res_t        expected_results[$];
    logic signed [31:0] table_x_copy [TABLE_DEPTH];
    logic signed [31:0] table_y_copy [TABLE_DEPTH];
    logic [4:0]         points_copy = 5'd2;
    logic signed [31:0] planned_x [TABLE_DEPTH];   // table as the generator has queued it

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int fail_count    = 0;
    int hold_req_cnt  = 0;
    int hold_ack_cnt  = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    table_linear_interpolator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (offer.command),
        .entry_index (offer.entry_index),
        .point_x     (offer.point_x),
        .point_y     (offer.point_y),
        .query_x     (offer.query_x),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_y    (result_y),
        .error_code  (error_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int clamp_points(input logic [4:0] v);
        int n;
        n = int'(v);
        if (n < 2) n = 2;
        if (n > TABLE_DEPTH) n = TABLE_DEPTH;
        return n;
    endfunction

    function automatic longint abs64(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Applies one accepted request to the table copy; queries queue their answer.
    function automatic void predict_request(input interp_req_t r);
        int          n;
        int          best;
        longint      q, d, best_d, x1, y1, dx, dy, dq, y, step;
        logic [64:0] mag_dx, mag_dy, mag_dq, prod, quot;
        logic        neg;
        interp_res_t res;
        if (r.command == CMD_WRITE)
        begin
            table_x_copy[r.entry_index] = r.point_x;
            table_y_copy[r.entry_index] = r.point_y;
            return;
        end
        n = clamp_points(points_copy);
        q = $signed(r.query_x);
        best = 0;
        best_d = abs64(q - table_x_copy[0]);
        for (int i = 1; i < n; i++)
        begin
            d = abs64(q - table_x_copy[i]);
            if (d < best_d)
            begin
                best_d = d;
                best = i;
            end
        end
        if (best == n - 1) best = n - 2;
        x1 = table_x_copy[best];
        y1 = table_y_copy[best];
        dx = table_x_copy[best + 1] - x1;
        if (dx == 0)
        begin
            res.result_y = '0;
            res.error_code = ERR_EQUAL_X;
        end
        else
        begin
            dy = table_y_copy[best + 1] - y1;
            dq = q - x1;
            mag_dx = abs64(dx);
            mag_dy = abs64(dy);
            mag_dq = abs64(dq);
            prod = mag_dy * mag_dq;
            quot = prod / mag_dx;
            if (quot > 65'h2_0000_0000) quot = 65'h2_0000_0000;
            neg = ((dy < 0) != (dq < 0)) != (dx < 0);
            step = quot[33:0];
            y = neg ? y1 - step : y1 + step;
            if (y > Q_MAX) y = Q_MAX;
            else if (y < Q_MIN) y = Q_MIN;
            res.result_y = y[31:0];
            res.error_code = ERR_OK;
        end
        expected_results.push_back(res);
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        fail_count++;
    endtask

    // unused fields carry random values so the block is seen to ignore them
    task automatic push_write(input logic [3:0] idx, input logic signed [31:0] px,
                              input logic signed [31:0] py);
        interp_req_t r;
        r.command = CMD_WRITE;
        r.entry_index = idx;
        r.point_x = px;
        r.point_y = py;
        r.query_x = $urandom;
        pending_reqs.push_back(r);
        planned_x[idx] = px;
    endtask

    task automatic push_query(input logic signed [31:0] qx);
        interp_req_t r;
        r.command = CMD_QUERY;
        r.entry_index = 4'($urandom);
        r.point_x = $urandom;
        r.point_y = $urandom;
        r.query_x = qx;
        pending_reqs.push_back(r);
    endtask

    task automatic push_random_mix(input int count);
        int                 n;
        int                 made;
        int                 slot;
        int                 shift;
        logic               desc;
        logic [31:0]        delta;
        logic signed [31:0] x;
        logic signed [31:0] offset;
        n = clamp_points(points_copy);
        made = 0;
        while (made < count)
        begin
            case ($urandom_range(9))
                0, 1:
                begin
                    // reload a monotonic table; an occasional zero step gives equal x
                    x = $urandom;
                    shift = $urandom_range(26);
                    desc = 1'($urandom_range(1));
                    for (int s = 0; s < n; s++)
                    begin
                        push_write(4'(s), x, $urandom);
                        delta = ($urandom_range(15) == 0) ? 32'd0
                                : ($urandom & ((32'd1 << shift) - 32'd1));
                        x = desc ? x - delta : x + delta;
                    end
                    made += n;
                end
                2, 3, 4, 5, 6:
                begin
                    slot = $urandom_range(n - 1);
                    offset = $urandom;
                    offset = offset >>> $urandom_range(31);
                    push_query(planned_x[slot] + offset);
                    made++;
                end
                7:
                begin
                    push_query($urandom);
                    made++;
                end
                8:
                begin
                    push_write(4'($urandom_range(15)), $urandom, $urandom);
                    made++;
                end
                default:
                begin
                    push_write(4'($urandom_range(15)),
                               $urandom_range(1) ? Q_MAX : Q_MIN,
                               $urandom_range(1) ? Q_MAX : Q_MIN);
                    made++;
                end
            endcase
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // register writes only with the block idle; writes give no result, so settle first
    task automatic set_points(input logic [4:0] v);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        points_copy = v;
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            offer <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_request(offer);
            if (!in_valid || in_ready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offer <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        interp_res_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected result y=%h err=%b",
                                              result_y, error_code));
                else
                begin
                    want = expected_results.pop_front();
                    if (result_y !== want.result_y)
                        report_mismatch($sformatf("result_y %h, expected %h",
                                                  result_y, want.result_y));
                    if (error_code !== want.error_code)
                        report_mismatch($sformatf("error_code %b, expected %b",
                                                  error_code, want.error_code));
                end
            end
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
        end
    end

    // long receiver hold-off, started on request from the stimulus
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (hold_ack_cnt != hold_req_cnt)
        begin
            hold_left <= HOLD_CYCLES;
            hold_ack_cnt <= hold_req_cnt;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int points_plan [8] = '{16, 0, 31, 9, 1, 17, 3, 2};
        int send_plan [4]   = '{0, 66, 0, 25};
        int stall_plan [4]  = '{0, 0, 66, 25};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // every slot gets written first so no query reads an unwritten entry
        push_write(4'd0, Q_MIN, Q_MIN);
        push_write(4'd1, Q_MAX, Q_MAX);
        for (int s = 2; s < TABLE_DEPTH - 1; s++)
            push_write(4'(s), (s - 8) <<< 20, ((s % 2) ? -1 : 1) * s * s * 65536);
        // last two slots share x: equal-x error at the top of a full table
        push_write(4'd15, 32'sd6 <<< 20, 32'sh0001_0000);
        // full-range segment, at reset count
        push_query(32'sd0);
        push_query(Q_MAX);
        push_query(Q_MIN);
        // steep segment: extrapolation saturates both ways
        push_write(4'd0, 32'sd0, 32'sd0);
        push_write(4'd1, 32'sh0001_0000, Q_MAX);
        push_query(Q_MAX);
        push_query(Q_MIN);
        // equal x on the segment
        push_write(4'd1, 32'sd0, 32'sd5);
        push_query(32'sd7);

        for (int p = 0; p < 8; p++)
        begin
            set_points(5'(points_plan[p]));
            send_idle_pct = send_plan[p % 4];
            stall_pct = stall_plan[p % 4];
            if (p == 0)
                hold_req_cnt++;     // receiver holds off while requests keep coming
            push_random_mix(ITEMS_PER_PHASE / 2);
            if (p == 5)
                wait_drained();     // sender pauses until every result is back
            push_random_mix(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
